// ===== hdl/bcmh_pkg.sv =====
// bcmh_pkg: shared types and constants of the brightness/contrast mapper
// with histogram; beat structs, command codes, register indexes, divider widths.
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bcmh_pkg;

    // payload widths
    localparam int CMD_W      = 2;
    localparam int PIX_W      = 8;
    localparam int IDX_W      = 5;
    localparam int FIELD_W    = 20;
    localparam int SET_W      = 8;
    localparam int GAIN_W     = 24;
    localparam int OFFS_W     = 34;

    // defaults of the top level parameters
    localparam int HIST_BINS_DEF   = 32;
    localparam int COUNT_WIDTH_DEF = 20;

    // commands
    localparam logic [CMD_W-1:0] CMD_MAP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam int WR_IDX_W = 1;
    localparam logic [WR_IDX_W-1:0] REG_BRIGHTNESS = 1'd0;
    localparam logic [WR_IDX_W-1:0] REG_CONTRAST   = 1'd1;

    // reset values of the settings and of the derived line
    localparam logic [SET_W-1:0]  SET_RESET  = 8'd100;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65793;

    // coefficient divider
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PIX_W-1:0] pixel_in;
        logic [IDX_W-1:0] bin_index;
    } req_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [FIELD_W-1:0] bin_count;
        logic [FIELD_W-1:0] peak_count;
        logic               count_saturated;
    } rsp_t;

    // gain q8.16 and offset signed q17.16 as used by the mapper
    typedef struct packed {
        logic        [GAIN_W-1:0] gain;
        logic signed [OFFS_W-1:0] offset;
    } line_t;

    // mapped beat handed from the mapper to the histogram
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PIX_W-1:0] level;
        logic [IDX_W-1:0] bin_index;
    } map_beat_t;

endpackage

`default_nettype wire

// ===== hdl/bcmh_div.sv =====
// bcmh_div: unsigned restoring divider, one quotient bit per cycle
// depends on bcmh_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcmh_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [bcmh_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [bcmh_pkg::DIV_DEN_W-1:0] dvs,
    output logic      [bcmh_pkg::DIV_NUM_W-1:0] quot,
    output logic                                rem_nz,
    output logic                                done
);
    import bcmh_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] num_next;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_DEN_W-1:0] dvs_reg;
    logic [DIV_DEN_W:0]   partial;
    logic                 ge;

    always_comb
    begin
        partial  = {rem_reg, num_reg[DIV_NUM_W-1]};
        ge       = partial >= {1'b0, dvs_reg};
        rem_next = ge ? DIV_DEN_W'(partial - {1'b0, dvs_reg}) : partial[DIV_DEN_W-1:0];
        // quotient bits shift in where the dividend bits leave
        num_next = {num_reg[DIV_NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            dvs_reg <= dvs;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quot   = num_reg;
    assign rem_nz = rem_reg != '0;
    assign done   = done_reg;

endmodule

`default_nettype wire

// ===== hdl/bcmh_coef.sv =====
// bcmh_coef: setting registers and the sequencer that derives gain and offset
// depends on bcmh_pkg and bcmh_div
`timescale 1ns / 1ps
`default_nettype none

module bcmh_coef (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [bcmh_pkg::WR_IDX_W-1:0] wr_index,
    input  wire logic [bcmh_pkg::SET_W-1:0]    wr_data,
    output bcmh_pkg::line_t                    line,
    output logic                               busy
);
    import bcmh_pkg::*;

    localparam logic [SET_W-1:0] SET_MAX      = 8'd200;
    localparam logic [14:0]      DEN_COMPRESS = 15'd25500;
    localparam logic [14:0]      GNUM_STRETCH = 15'd25500;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_GAIN,
        S_GAIN_WAIT,
        S_OFFS,
        S_OFFS_WAIT
    } state_t;

    state_t                    state_reg;
    logic [SET_W-1:0]          brightness_reg;
    logic [SET_W-1:0]          contrast_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [OFFS_W-1:0]  offset_reg;
    logic signed [OFFS_W-1:0]  offset_next;

    logic [14:0]               den_reg;
    logic [14:0]               gnum_reg;
    logic signed [25:0]        tnum_reg;
    logic                      neg_reg;

    logic [SET_W-1:0]          bset;
    logic [SET_W-1:0]          cset;
    logic signed [17:0]        br_x;
    logic signed [17:0]        c_x;
    logic signed [17:0]        den_x;
    logic signed [17:0]        numa_x;
    logic signed [17:0]        lin_x;
    logic signed [25:0]        t_str;
    logic signed [25:0]        t_cmp;
    logic                      stretch;
    logic signed [41:0]        off_num;
    logic [DIV_NUM_W-1:0]      off_mag;
    logic [OFFS_W-1:0]         q34;

    logic                      div_start;
    logic [DIV_NUM_W-1:0]      div_num;
    logic [DIV_DEN_W-1:0]      div_dvs;
    logic [DIV_NUM_W-1:0]      div_quot;
    logic                      div_rem_nz;
    logic                      div_done;

    always_comb
    begin
        bset    = (brightness_reg > SET_MAX) ? SET_MAX : brightness_reg;
        cset    = (contrast_reg > SET_MAX) ? SET_MAX : contrast_reg;
        br_x    = $signed({10'd0, bset}) - 18'sd100;
        c_x     = $signed({10'd0, cset}) - 18'sd100;
        stretch = c_x > 18'sd0;
        den_x   = 18'sd25500 - 18'sd254 * c_x;
        numa_x  = 18'sd25600 + 18'sd256 * c_x;
        lin_x   = 18'sd100 * br_x - 18'sd127 * c_x;
        t_str   = 26'(lin_x) * 26'sd255;
        t_cmp   = 26'(numa_x) * 26'(br_x) - 26'sd32640 * 26'(c_x);

        // rounding half up: floor((2n + d) / 2d) with n already scaled by 2^16
        off_num = (42'(tnum_reg) <<< 17) + $signed({27'd0, den_reg});
        off_mag = off_num[41] ? DIV_NUM_W'(-off_num) : off_num[DIV_NUM_W-1:0];

        div_start = (state_reg == S_GAIN) || (state_reg == S_OFFS);
        div_num   = (state_reg == S_GAIN)
                  ? ({8'd0, gnum_reg, 17'd0} + {25'd0, den_reg})
                  : off_mag;
        div_dvs   = {den_reg, 1'b0};

        // floor of a negative quotient rounds away from zero
        q34         = div_quot[OFFS_W-1:0];
        offset_next = neg_reg ? $signed(OFFS_W'(q34 + OFFS_W'(div_rem_nz)) ^ {OFFS_W{1'b1}})
                                + OFFS_W'(1)
                              : $signed(q34);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            brightness_reg <= SET_RESET;
            contrast_reg   <= SET_RESET;
            gain_reg       <= GAIN_RESET;
            offset_reg     <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                // a later write simply restarts the derivation
                unique case (wr_index)
                    REG_BRIGHTNESS: brightness_reg <= wr_data;
                    REG_CONTRAST:   contrast_reg   <= wr_data;
                    default:        contrast_reg   <= contrast_reg;
                endcase
                state_reg <= S_PREP;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:      state_reg <= S_IDLE;
                    S_PREP:      state_reg <= S_GAIN;
                    S_GAIN:      state_reg <= S_GAIN_WAIT;
                    S_GAIN_WAIT:
                    begin
                        if (div_done)
                        begin
                            gain_reg  <= div_quot[GAIN_W-1:0];
                            state_reg <= S_OFFS;
                        end
                    end
                    S_OFFS:      state_reg <= S_OFFS_WAIT;
                    S_OFFS_WAIT:
                    begin
                        if (div_done)
                        begin
                            offset_reg <= offset_next;
                            state_reg  <= S_IDLE;
                        end
                    end
                    default:     state_reg <= S_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PREP)
        begin
            den_reg  <= stretch ? den_x[14:0] : DEN_COMPRESS;
            gnum_reg <= stretch ? GNUM_STRETCH : numa_x[14:0];
            tnum_reg <= stretch ? t_str : t_cmp;
        end
        if (state_reg == S_OFFS)
        begin
            neg_reg <= off_num[41];
        end
    end

    bcmh_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .dvs    (div_dvs),
        .quot   (div_quot),
        .rem_nz (div_rem_nz),
        .done   (div_done)
    );

    assign line.gain   = gain_reg;
    assign line.offset = offset_reg;
    assign busy        = state_reg != S_IDLE;

endmodule

`default_nettype wire

// ===== hdl/bcmh_map.sv =====
// bcmh_map: input register and the gain/offset mapping with rounding and clamp
// depends on bcmh_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcmh_map (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_take,
    input  wire bcmh_pkg::req_t       req,
    input  wire bcmh_pkg::line_t      line,
    input  wire logic                 s2_take,
    output logic                      ready,
    output logic                      s2_valid,
    output bcmh_pkg::map_beat_t       s2_beat
);
    import bcmh_pkg::*;

    logic               s1_valid_reg;
    req_t               s1_reg;
    logic               s2_valid_reg;
    map_beat_t          s2_reg;
    map_beat_t          s2_next;
    logic               s1_move;
    logic [31:0]        prod;
    logic signed [35:0] acc;

    assign s1_move = s1_valid_reg && (!s2_valid_reg || s2_take);
    assign ready   = !s1_valid_reg || s1_move;

    always_comb
    begin
        prod = line.gain * s1_reg.pixel_in;
        acc  = $signed({4'd0, prod}) + 36'(line.offset) + 36'sd32768;
        s2_next.cmd       = s1_reg.cmd;
        s2_next.bin_index = s1_reg.bin_index;
        if (acc[35])
        begin
            s2_next.level = '0;
        end
        else if (|acc[34:24])
        begin
            s2_next.level = '1;
        end
        else
        begin
            s2_next.level = acc[23:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_take)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_reg <= req;
        end
        if (s1_move)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_beat  = s2_reg;

endmodule

`default_nettype wire

// ===== hdl/bcmh_hist.sv =====
// bcmh_hist: histogram memory with per-bin valid bits, count update, peak and
// saturation tracking, and the result register; depends on bcmh_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcmh_hist #(
    parameter int HIST_BINS   = bcmh_pkg::HIST_BINS_DEF,
    parameter int COUNT_WIDTH = bcmh_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s2_valid,
    input  wire bcmh_pkg::map_beat_t  s2_beat,
    output logic                      s2_take,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output bcmh_pkg::rsp_t            rsp
);
    import bcmh_pkg::*;

    localparam int BIN_W = $clog2(HIST_BINS);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] mem [HIST_BINS];
    logic [HIST_BINS-1:0]   vld_reg;

    // read stage
    logic [16:0]            bin_prod;
    logic [8:0]             bin_w;
    logic                   s2_rng;
    logic [BIN_W-1:0]       s2_addr;

    // update stage
    logic                   s3_valid_reg;
    logic [CMD_W-1:0]       s3_cmd_reg;
    logic [PIX_W-1:0]       s3_level_reg;
    logic [BIN_W-1:0]       s3_addr_reg;
    logic                   s3_rng_reg;
    logic [COUNT_WIDTH-1:0] mem_q_reg;
    logic                   vld_q_reg;
    logic                   fwd_sel_reg;
    logic [COUNT_WIDTH-1:0] fwd_val_reg;

    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] new_cnt;
    logic [COUNT_WIDTH-1:0] peak_reg;
    logic [COUNT_WIDTH-1:0] peak_next;
    logic                   sat_reg;
    logic                   sat_next;
    logic                   write_now;
    logic                   clear_now;

    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;
    logic                   out_move;

    assign out_move = s3_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign s2_take  = s2_valid && (!s3_valid_reg || out_move);

    always_comb
    begin
        bin_prod = 17'(s2_beat.level) * 17'(HIST_BINS);
        bin_w    = bin_prod[16:8];
        s2_rng   = 32'(s2_beat.bin_index) < 32'(HIST_BINS);
        if (s2_beat.cmd == CMD_MAP)
        begin
            s2_addr = bin_w[BIN_W-1:0];
        end
        else if (s2_rng)
        begin
            s2_addr = BIN_W'(s2_beat.bin_index);
        end
        else
        begin
            s2_addr = '0;
        end
    end

    always_comb
    begin
        cnt       = fwd_sel_reg ? fwd_val_reg : (vld_q_reg ? mem_q_reg : '0);
        new_cnt   = (cnt == CNT_MAX) ? cnt : cnt + COUNT_WIDTH'(1);
        write_now = out_move && (s3_cmd_reg == CMD_MAP);
        clear_now = out_move && (s3_cmd_reg == CMD_CLEAR);
        peak_next = peak_reg;
        sat_next  = sat_reg;
        rsp_next.pixel_out = '0;
        rsp_next.bin_count = '0;
        unique case (s3_cmd_reg)
            CMD_MAP:
            begin
                rsp_next.pixel_out = s3_level_reg;
                if (new_cnt > peak_reg)
                begin
                    peak_next = new_cnt;
                end
                if (new_cnt == CNT_MAX)
                begin
                    sat_next = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (s3_rng_reg)
                begin
                    rsp_next.bin_count = FIELD_W'(cnt);
                end
            end
            CMD_CLEAR:
            begin
                peak_next = '0;
                sat_next  = 1'b0;
            end
            default:
            begin
                sat_next = sat_reg;
            end
        endcase
        rsp_next.peak_count      = FIELD_W'(peak_next);
        rsp_next.count_saturated = sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            vld_reg       <= '0;
            peak_reg      <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            if (s2_take)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (out_move)
            begin
                s3_valid_reg <= 1'b0;
            end

            if (out_move)
            begin
                rsp_valid_reg <= 1'b1;
                peak_reg      <= peak_next;
                sat_reg       <= sat_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (clear_now)
            begin
                vld_reg <= '0;
            end
            else if (write_now)
            begin
                vld_reg[s3_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_now)
        begin
            mem[s3_addr_reg] <= new_cnt;
        end
        if (s2_take)
        begin
            mem_q_reg    <= mem[s2_addr];
            vld_q_reg    <= vld_reg[s2_addr];
            s3_cmd_reg   <= s2_beat.cmd;
            s3_level_reg <= s2_beat.level;
            s3_addr_reg  <= s2_addr;
            s3_rng_reg   <= s2_rng;
            // bypass the update or clear committed at this same edge
            fwd_sel_reg  <= clear_now || (write_now && (s3_addr_reg == s2_addr));
            fwd_val_reg  <= clear_now ? '0 : new_cnt;
        end
        if (out_move)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== hdl/brightness_contrast_map_hist_top.sv =====
// brightness_contrast_map_hist_top: pixel mapper with histogram, top level
// depends on bcmh_pkg, bcmh_coef, bcmh_map, bcmh_hist
//
//  channel   direction  handshake              payload
//  req       in         req_valid / req_stall  cmd, pixel_in, bin_index
//  rsp       out        rsp_valid / rsp_stall  pixel_out, bin_count, peak_count,
//                                              count_saturated
//  config    in         wr_en                  wr_index, wr_data
//
// one beat per cycle unless req_stall or rsp_stall holds the flow; a result passes the input,
// map and bin read stage registers before it lands in the output register
// a setting write recomputes gain and offset on a 40-step shared divider;
// req_stall stays high from the write cycle until the new offset is stored
// reset restores both settings to 100 and empties the histogram at once
// rsp_stall holds the output register; the stages behind it keep filling
`timescale 1ns / 1ps
`default_nettype none

module brightness_contrast_map_hist_top #(
    parameter int HIST_BINS   = bcmh_pkg::HIST_BINS_DEF,
    parameter int COUNT_WIDTH = bcmh_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire bcmh_pkg::req_t                req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output bcmh_pkg::rsp_t                     rsp,
    input  wire logic                          wr_en,
    input  wire logic [bcmh_pkg::WR_IDX_W-1:0] wr_index,
    input  wire logic [bcmh_pkg::SET_W-1:0]    wr_data
);
    import bcmh_pkg::*;

    line_t     line;
    logic      coef_busy;
    logic      map_ready;
    logic      req_take;
    logic      s2_valid;
    logic      s2_take;
    map_beat_t s2_beat;

    assign req_stall = !map_ready || coef_busy || wr_en;
    assign req_take  = req_valid && !req_stall;

    bcmh_coef u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .line     (line),
        .busy     (coef_busy)
    );

    bcmh_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (req_take),
        .req      (req),
        .line     (line),
        .s2_take  (s2_take),
        .ready    (map_ready),
        .s2_valid (s2_valid),
        .s2_beat  (s2_beat)
    );

    bcmh_hist #(
        .HIST_BINS   (HIST_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (s2_valid),
        .s2_beat   (s2_beat),
        .s2_take   (s2_take),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
